// ----- design/setr_pkg.sv -----
// Package for the sequenced event credit tracker.
// Holds word structs, status codes, register indexes and the cell state type.
`default_nettype none
package setr_pkg;

  typedef enum logic [3:0] {
    ST_SELF        = 4'd0,
    ST_FILTERED    = 4'd1,
    ST_KEEPALIVE   = 4'd2,
    ST_CREDITED    = 4'd3,
    ST_DUP         = 4'd4,
    ST_GAPFILL     = 4'd5,
    ST_DRAIN       = 4'd6,
    ST_DRAINREJECT = 4'd7,
    ST_BIGGAP      = 4'd8,
    ST_RESET       = 4'd9,
    ST_REORDER     = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    REG_ACCEPT_MODE  = 2'd0,
    REG_PINNED_ID    = 2'd1,
    REG_PINNED_VALID = 2'd2,
    REG_OWN_ID       = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SEARCH = 2'd1,
    PH_UPDATE = 2'd2,
    PH_OUT    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [47:0] source_id;
    logic        mode;
    logic [31:0] seq_counter;
    logic [31:0] sender_time_ms;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  slot_index;
    logic [10:0] credit;
    logic [10:0] gap_fill;
    logic [15:0] drain_gap;
    logic [15:0] drain_dt_ms;
    logic [25:0] span_us;
    logic [31:0] total_count;
    logic [31:0] resync_total;
  } out_word_t;

  // one table entry
  typedef struct packed {
    logic        used;
    logic [47:0] sender;
    logic [31:0] seen;
    logic        has_clicks;
    logic [31:0] last_seq;
    logic [31:0] last_time;
  } slot_t;

  // search token passed along the chain
  typedef struct packed {
    logic        hit;
    logic        free;
    logic [31:0] oldest;
  } scan_t;

  // command broadcast to every cell
  typedef struct packed {
    logic        wr;
    logic        claim;
    logic        adv;
    logic        set_clicks;
    logic [47:0] sender;
    logic [31:0] seen;
    logic [31:0] seq;
    logic [31:0] ts;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ----- design/setr_cell.sv -----
// One sender table slot and its link in the search chain.
// Depends on setr_pkg.
`default_nettype none
module setr_cell
  import setr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic [47:0] id,
  input  wire scan_t     scan_in,
  output scan_t          scan_out,
  output logic           match,
  output logic           free_pick,
  output logic           old_pick,
  input  wire logic      sel,
  input  wire cell_cmd_t cmd,
  output slot_t          slot
);

  always_comb begin
    match     = slot.used && slot.sender == id;
    free_pick = !slot.used && !scan_in.free;
    old_pick  = slot.used && slot.seen < scan_in.oldest;
    scan_out.hit    = scan_in.hit | match;
    scan_out.free   = scan_in.free | !slot.used;
    scan_out.oldest = old_pick ? slot.seen : scan_in.oldest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.used       <= 1'b0;
      slot.has_clicks <= 1'b0;
    end else if (sel && cmd.wr) begin
      slot.used   <= 1'b1;
      slot.sender <= cmd.sender;
      slot.seen   <= cmd.seen;
      if (cmd.claim) begin
        slot.has_clicks <= cmd.set_clicks;
        slot.last_seq   <= cmd.adv ? cmd.seq : 32'd0;
        slot.last_time  <= cmd.adv ? cmd.ts : 32'd0;
      end else begin
        if (cmd.set_clicks) slot.has_clicks <= 1'b1;
        if (cmd.adv) begin
          slot.last_seq  <= cmd.seq;
          slot.last_time <= cmd.ts;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/sequenced_event_credit_tracker_core.sv -----
// Sequenced event credit tracker: chain of slot cells plus classifier.
// out_valid rises once the word has passed the search and update phases (search only
// for self and filtered words) and holds until out_ready.
// One word at a time: idle, search, update, output (no update for self and filtered
// words); a new word is accepted only in idle, and the output can stall.
// Synchronous reset clears slot valid bits, latch, totals and registers.
`default_nettype none
module sequenced_event_credit_tracker_core
  import setr_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [47:0] cfg_data
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic        accept_mode, pinned_valid, latched_valid;
  logic [47:0] pinned_id, own_id, latched_sender;
  logic [31:0] click_total, resync_events;
  phase_t      phase, phase_next;
  in_word_t    item;
  logic        live;
  logic [SW-1:0] pick;
  logic          pick_hit;
  slot_t         cur;
  out_word_t     out_data_next;

  scan_t     chain [SLOTS+1];
  logic [SLOTS-1:0] match, free_pick, old_pick, sel;
  slot_t     slots [SLOTS];
  cell_cmd_t cmd;

  assign chain[0] = '{hit: 1'b0, free: 1'b0, oldest: slots[0].seen};

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    setr_cell u_cell (
      .clk, .rst, .id(item.source_id), .scan_in(chain[g]), .scan_out(chain[g+1]),
      .match(match[g]), .free_pick(free_pick[g]), .old_pick(old_pick[g]),
      .sel(sel[g]), .cmd, .slot(slots[g])
    );
  end

  // choose slot: hit, else first free, else last strictly-older (first min)
  logic [SW-1:0] pick_c;
  always_comb begin
    pick_c = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (chain[SLOTS].hit) begin
        if (match[i]) pick_c = SW'(i);
      end else if (chain[SLOTS].free) begin
        if (free_pick[i]) pick_c = SW'(i);
      end else if (old_pick[i]) begin
        pick_c = SW'(i);
      end
    end
  end

  assign cur = slots[pick];

  // classification
  logic [31:0] dt, gap, back;
  logic [3:0]  st;
  logic [10:0] credit;
  logic        adv, resync;
  logic [25:0] span;
  always_comb begin
    dt     = item.sender_time_ms - cur.last_time;
    gap    = item.seq_counter - cur.last_seq - 32'd1;
    back   = cur.last_seq - item.seq_counter;
    st     = ST_CREDITED;
    credit = 11'd1;
    adv    = 1'b1;
    resync = 1'b0;
    if (!pick_hit) begin
      st = ST_CREDITED;
    end else if (!cur.has_clicks) begin
      st = ST_CREDITED;
    end else if (item.seq_counter == cur.last_seq) begin
      st = ST_DUP; credit = 11'd0;
    end else if (item.seq_counter > cur.last_seq) begin
      if (gap == 32'd0) st = ST_CREDITED;
      else if (gap <= 32'd1024) begin
        st = ST_GAPFILL; credit = 11'(gap) + 11'd1;
      end else if (gap <= 32'd65535) begin
        if (dt > 32'd100 && dt < 32'd60000) st = ST_DRAIN;
        else begin st = ST_DRAINREJECT; resync = 1'b1; end
      end else begin
        st = ST_BIGGAP; resync = 1'b1;
      end
    end else if (back > 32'd1024 || (dt >= 32'h8000_0000 && dt < 32'hFFFF_15A0)) begin
      st = ST_RESET; resync = 1'b1;
    end else begin
      st = ST_REORDER; credit = 11'd0; adv = 1'b0;
    end
    span = '0;
    if (credit > 11'd1)
      span = (dt != 32'd0 && dt < 32'd60000) ? 26'(dt * 32'd1000) : 26'd1000000;
  end

  // accept filter
  logic self_c, pass_c;
  always_comb begin
    self_c = in_data.source_id == own_id;
    if (accept_mode) pass_c = 1'b1;
    else if (pinned_valid) pass_c = pinned_id == in_data.source_id;
    else pass_c = !latched_valid || latched_sender == in_data.source_id;
  end

  logic [3:0] in_status;
  always_comb begin
    phase_next = phase;
    in_ready   = (phase == PH_IDLE);
    unique case (phase)
      PH_IDLE:   if (in_valid) phase_next = PH_SEARCH;
      PH_SEARCH: phase_next = live ? PH_UPDATE : PH_OUT;
      PH_UPDATE: phase_next = PH_OUT;
      PH_OUT:    if (out_ready) phase_next = PH_IDLE;
      default:   phase_next = PH_IDLE;
    endcase
    for (int i = 0; i < SLOTS; i++) sel[i] = (pick == SW'(i));
    cmd.wr         = (phase == PH_SEARCH && live) || (phase == PH_UPDATE && item.mode);
    cmd.claim      = (phase == PH_SEARCH) && !chain[SLOTS].hit;
    cmd.adv        = 1'b0;
    cmd.set_clicks = 1'b0;
    cmd.sender     = item.source_id;
    cmd.seen       = item.now_ms;
    cmd.seq        = item.seq_counter;
    cmd.ts         = item.sender_time_ms;
    if (phase == PH_SEARCH) begin
      for (int i = 0; i < SLOTS; i++) sel[i] = (pick_c == SW'(i));
    end else if (phase == PH_UPDATE) begin
      cmd.adv        = adv;
      cmd.set_clicks = credit != 11'd0;
    end
  end

  always_comb begin
    out_data_next = out_data;
    if (phase == PH_SEARCH) begin
      out_data_next = '0;
      out_data_next.total_count  = click_total;
      out_data_next.resync_total = resync_events;
      if (!live) out_data_next.status = in_status;
      else begin
        out_data_next.status     = ST_KEEPALIVE;
        out_data_next.slot_index = 3'(pick_c);
      end
    end else if (phase == PH_UPDATE && item.mode) begin
      out_data_next.status       = st;
      out_data_next.credit       = credit;
      out_data_next.gap_fill     = (st == ST_GAPFILL) ? 11'(gap) : 11'd0;
      out_data_next.drain_gap    = (st == ST_DRAIN) ? 16'(gap) : 16'd0;
      out_data_next.drain_dt_ms  = (st == ST_DRAIN) ? 16'(dt) : 16'd0;
      out_data_next.span_us      = span;
      out_data_next.total_count  = click_total + 32'(credit);
      out_data_next.resync_total = resync_events + 32'(resync);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) phase <= PH_IDLE;
    else phase <= phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_mode <= 1'b0; pinned_valid <= 1'b0; latched_valid <= 1'b0;
      pinned_id <= '0; own_id <= '0; latched_sender <= '0;
      click_total <= '0; resync_events <= '0; live <= 1'b0;
      in_status <= ST_SELF; pick <= '0; pick_hit <= 1'b0;
      out_data <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACCEPT_MODE: begin
            if (cfg_data[0] != accept_mode) latched_valid <= 1'b0;
            accept_mode <= cfg_data[0];
          end
          REG_PINNED_ID:    pinned_id <= cfg_data;
          REG_PINNED_VALID: pinned_valid <= cfg_data[0];
          REG_OWN_ID:       own_id <= cfg_data;
          default: ;
        endcase
      end
      if (phase == PH_IDLE && in_valid) begin
        item <= in_data;
        live <= !self_c && pass_c;
        in_status <= self_c ? ST_SELF : ST_FILTERED;
        if (!self_c && !accept_mode && !pinned_valid && !latched_valid) begin
          latched_valid  <= 1'b1;
          latched_sender <= in_data.source_id;
        end
      end
      if (phase == PH_SEARCH) begin
        pick     <= pick_c;
        pick_hit <= chain[SLOTS].hit;
      end
      out_data <= out_data_next;
      if (phase == PH_UPDATE && item.mode) begin
        click_total   <= click_total + 32'(credit);
        resync_events <= resync_events + 32'(resync);
      end
    end
  end

  assign out_valid = (phase == PH_OUT);

  a_one_pick: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SEARCH |-> $countones(match) <= 1) else $error("duplicate sender slots");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("output dropped");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("overlap");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for sequenced_event_credit_tracker_core: directed table, then random event packets.
// Depends on setr_pkg; output words are checked against table values or a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import setr_pkg::*;

  localparam int NSLOT = 8;
  localparam int POOL = 12;
  localparam int LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  sequenced_event_credit_tracker_core #(.SLOTS(NSLOT)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // tracker mirror
  logic        m_sum_mode;
  logic [47:0] m_pin_id;
  logic        m_pin_on;
  logic [47:0] m_own_id;
  logic [47:0] m_sender [NSLOT];
  logic [31:0] m_seen [NSLOT];
  logic        m_has_clicks [NSLOT];
  logic [31:0] m_last_seq [NSLOT];
  logic [31:0] m_last_ts [NSLOT];
  int          m_used;
  logic [47:0] m_latch_id;
  logic        m_latch_on;
  logic [31:0] m_clicks;
  logic [31:0] m_resyncs;

  out_word_t expected_words[$];
  int mismatches = 0;
  int cycles = 0;
  bit no_idle = 0;
  bit long_hold = 0;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t e;
  } row_t;
  row_t rows[$];

  logic [47:0] id_pool [POOL];
  logic [31:0] gen_seq [POOL];
  logic [31:0] gen_ts [POOL];
  logic [31:0] clock_ms;

  function automatic bit sender_ok(logic [47:0] id);
    if (m_sum_mode) return 1'b1;
    if (m_pin_on) return m_pin_id == id;
    if (!m_latch_on) begin
      m_latch_id = id;
      m_latch_on = 1'b1;
      return 1'b1;
    end
    return m_latch_id == id;
  endfunction

  function automatic int find_slot(logic [47:0] id, logic [31:0] now);
    int pick;
    logic [31:0] oldest;
    for (int i = 0; i < m_used; i++) begin
      if (m_sender[i] == id) begin
        m_seen[i] = now;
        return i;
      end
    end
    if (m_used < NSLOT) begin
      pick = m_used;
      m_used++;
    end else begin
      pick = 0;
      oldest = m_seen[0];
      for (int i = 1; i < NSLOT; i++) begin
        if (m_seen[i] < oldest) begin
          pick = i;
          oldest = m_seen[i];
        end
      end
    end
    m_sender[pick] = id;
    m_seen[pick] = now;
    m_has_clicks[pick] = 1'b0;
    m_last_seq[pick] = '0;
    m_last_ts[pick] = '0;
    return pick;
  endfunction

  function automatic out_word_t credit_packet(in_word_t w);
    out_word_t r;
    int s;
    logic [31:0] last, dt, gap, back, cr;
    bit adv;
    r = '0;
    adv = 1'b1;
    if (w.source_id == m_own_id) begin
      r.status = ST_SELF;
    end else if (!sender_ok(w.source_id)) begin
      r.status = ST_FILTERED;
    end else begin
      s = find_slot(w.source_id, w.now_ms);
      r.slot_index = s[2:0];
      if (!w.mode) begin
        r.status = ST_KEEPALIVE;
      end else begin
        last = m_last_seq[s];
        dt = w.sender_time_ms - m_last_ts[s];
        cr = 1;
        r.status = ST_CREDITED;
        if (m_has_clicks[s]) begin
          if (w.seq_counter == last) begin
            cr = 0;
            r.status = ST_DUP;
          end else if (w.seq_counter > last) begin
            gap = w.seq_counter - last - 1;
            if (gap == 0) begin
              r.status = ST_CREDITED;
            end else if (gap <= 1024) begin
              cr += gap;
              r.gap_fill = gap[10:0];
              r.status = ST_GAPFILL;
            end else if (gap <= 65535) begin
              if (dt > 100 && dt < 60000) begin
                r.status = ST_DRAIN;
                r.drain_gap = gap[15:0];
                r.drain_dt_ms = dt[15:0];
              end else begin
                r.status = ST_DRAINREJECT;
                m_resyncs++;
              end
            end else begin
              r.status = ST_BIGGAP;
              m_resyncs++;
            end
          end else begin
            back = last - w.seq_counter;
            if (back > 1024 || (dt >= 32'h8000_0000 && dt < 32'hFFFF_15A0)) begin
              r.status = ST_RESET;
              m_resyncs++;
            end else begin
              cr = 0;
              r.status = ST_REORDER;
              adv = 1'b0;
            end
          end
        end
        if (cr > 1) r.span_us = (dt != 0 && dt < 60000) ? 26'(dt * 1000) : 26'd1000000;
        r.credit = cr[10:0];
        m_clicks += cr;
        if (cr > 0) m_has_clicks[s] = 1'b1;
        if (adv) begin
          m_last_seq[s] = w.seq_counter;
          m_last_ts[s] = w.sender_time_ms;
        end
      end
    end
    r.total_count = m_clicks;
    r.resync_total = m_resyncs;
    return r;
  endfunction

  function automatic int pick_gap();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic write_reg(reg_index_t idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ACCEPT_MODE: begin
        if (val[0] != m_sum_mode) m_latch_on = 1'b0;
        m_sum_mode = val[0];
      end
      REG_PINNED_ID: m_pin_id = val;
      REG_PINNED_VALID: m_pin_on = val[0];
      REG_OWN_ID: m_own_id = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_word(in_word_t w, bit typed, out_word_t e);
    int n;
    out_word_t p;
    n = pick_gap();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(negedge clk); while (!in_ready);
    p = credit_packet(w);
    expected_words.push_back(typed ? e : p);
    @(posedge clk);
  endtask

  function automatic in_word_t make_packet();
    in_word_t w;
    int k, c;
    k = $urandom_range(0, POOL - 1);
    w.source_id = id_pool[k];
    c = $urandom_range(0, 99);
    if (c < 3) w.source_id = 48'({$urandom, $urandom});
    else if (c < 5) w.source_id = m_own_id;
    w.mode = ($urandom_range(0, 9) != 0);
    c = $urandom_range(0, 99);
    if (c < 45) begin
      gen_seq[k] += 1;
      gen_ts[k] += $urandom_range(1, 200);
    end else if (c < 52) begin
      gen_ts[k] += $urandom_range(0, 50);
    end else if (c < 64) begin
      gen_seq[k] += $urandom_range(2, 1025);
      gen_ts[k] += $urandom_range(0, 70000);
    end else if (c < 72) begin
      gen_seq[k] += $urandom_range(1026, 65536);
      gen_ts[k] += $urandom_range(50, 61000);
    end else if (c < 77) begin
      gen_seq[k] += $urandom_range(65537, 32'h7FFF_FFFF);
      gen_ts[k] += $urandom_range(1, 1000);
    end else if (c < 83) begin
      gen_seq[k] -= $urandom_range(1, 1024);
      gen_ts[k] += $urandom_range(0, 100);
    end else if (c < 87) begin
      gen_seq[k] -= $urandom_range(1025, 32'h7FFF_FFFF);
    end else if (c < 91) begin
      gen_seq[k] += 1;
      gen_ts[k] -= $urandom_range(60001, 32'h7FFF_FFFF);
    end else begin
      gen_seq[k] = $urandom;
      gen_ts[k] = $urandom;
    end
    w.seq_counter = gen_seq[k];
    w.sender_time_ms = gen_ts[k];
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, 50);
    w.now_ms = clock_ms;
    return w;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[sequenced_event_credit_tracker_core] ERROR");
      $finish;
    end
  end

  // receiver
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = pick_gap();
      if (long_hold) begin
        long_hold = 0;
        n = 300;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  // checker: sample between edges so acceptance is unambiguous
  always @(negedge clk) begin
    out_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data);
      end else begin
        e = expected_words.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp st=%0d sl=%0d cr=%0d gf=%0d dg=%0d dt=%0d sp=%0d",
                     e.status, e.slot_index, e.credit, e.gap_fill, e.drain_gap,
                     e.drain_dt_ms, e.span_us);
            $display("          exp tot=%0d rs=%0d", e.total_count, e.resync_total);
            $display("          got st=%0d sl=%0d cr=%0d gf=%0d dg=%0d dt=%0d sp=%0d",
                     out_data.status, out_data.slot_index, out_data.credit,
                     out_data.gap_fill, out_data.drain_gap, out_data.drain_dt_ms,
                     out_data.span_us);
            $display("          got tot=%0d rs=%0d", out_data.total_count,
                     out_data.resync_total);
          end
        end
      end
    end
  end

  task automatic add_row(logic [47:0] id, logic md, logic [31:0] sq, logic [31:0] ts,
                         logic [31:0] now, bit typed, out_word_t e);
    row_t r;
    r.w = '{source_id: id, mode: md, seq_counter: sq, sender_time_ms: ts, now_ms: now};
    r.typed = typed;
    r.e = e;
    rows.push_back(r);
  endtask

  initial begin
    out_word_t e;
    logic [47:0] ida;
    m_sum_mode = 0; m_pin_id = '0; m_pin_on = 0; m_own_id = '0;
    m_used = 0; m_latch_id = '0; m_latch_on = 0; m_clicks = '0; m_resyncs = '0;
    foreach (m_has_clicks[i]) m_has_clicks[i] = 1'b0;
    clock_ms = 32'd5000;
    foreach (id_pool[i]) begin
      id_pool[i] = 48'({$urandom, $urandom});
      gen_seq[i] = $urandom;
      gen_ts[i] = $urandom;
    end
    id_pool[0] = 48'hFFFF_FFFF_FFFF;
    id_pool[1] = 48'h0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_ACCEPT_MODE, 48'd1);
    write_reg(REG_OWN_ID, 48'hAAAA_AAAA_AAAA);
    write_reg(REG_PINNED_ID, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_PINNED_VALID, 48'd0);

    ida = 48'h0000_0000_0001;
    e = '0; e.status = ST_SELF;
    add_row(48'hAAAA_AAAA_AAAA, 1'b1, 32'd7, 32'd7, 32'd1, 1, e);
    e = '0; e.status = ST_KEEPALIVE;
    add_row(ida, 1'b0, 32'd0, 32'd0, 32'd10, 1, e);
    e = '0; e.status = ST_CREDITED; e.credit = 11'd1; e.total_count = 32'd1;
    add_row(ida, 1'b1, 32'd100, 32'd1000, 32'd11, 1, e);
    e = '0; e.status = ST_DUP; e.total_count = 32'd1;
    add_row(ida, 1'b1, 32'd100, 32'd1010, 32'd12, 1, e);
    e = '0;
    add_row(ida, 1'b1, 32'd101, 32'd1020, 32'd13, 0, e);
    add_row(ida, 1'b1, 32'd111, 32'd1030, 32'd14, 0, e);
    add_row(ida, 1'b1, 32'd1136, 32'd1040, 32'd15, 0, e);
    add_row(ida, 1'b1, 32'd2162, 32'd1540, 32'd16, 0, e);
    add_row(ida, 1'b1, 32'd4200, 32'd1560, 32'd17, 0, e);
    add_row(ida, 1'b1, 32'd200000, 32'd1600, 32'd18, 0, e);
    add_row(ida, 1'b1, 32'd199995, 32'd1610, 32'd19, 0, e);
    add_row(ida, 1'b1, 32'd190000, 32'd1620, 32'd20, 0, e);
    add_row(ida, 1'b1, 32'd190001, 32'd1620 - 32'd70000, 32'd21, 0, e);
    add_row(ida, 1'b1, 32'd191026, 32'hFFFF_0000, 32'd22, 0, e);
    add_row(ida, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, e);
    add_row(48'hFFFF_FFFF_FFFF, 1'b1, 32'd0, 32'd0, 32'd0, 0, e);
    add_row(48'hFFFF_FFFF_FFFF, 1'b1, 32'd2, 32'd50000, 32'd1, 0, e);
    for (int i = 2; i < 10; i++)
      add_row(48'h5555_5555_0000 + i, 1'b1, 32'(i), 32'(i * 3), 32'(30 + i), 0, e);
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].e);
    in_valid <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_ACCEPT_MODE, 48'd0);
          write_reg(REG_PINNED_VALID, 48'd0);
          write_reg(REG_OWN_ID, 48'h0);
        end
        1: begin
          write_reg(REG_PINNED_ID, id_pool[2]);
          write_reg(REG_PINNED_VALID, 48'd1);
          write_reg(REG_OWN_ID, 48'hFFFF_FFFF_FFFF);
        end
        2: begin
          write_reg(REG_ACCEPT_MODE, 48'd1);
          write_reg(REG_OWN_ID, id_pool[3]);
        end
        3: begin
          write_reg(REG_PINNED_ID, 48'h0);
          write_reg(REG_OWN_ID, 48'({$urandom, $urandom}));
        end
        4: begin
          write_reg(REG_ACCEPT_MODE, 48'd0);
          write_reg(REG_PINNED_VALID, 48'd0);
        end
        default: begin
          write_reg(REG_ACCEPT_MODE, 48'd1);
          write_reg(REG_OWN_ID, 48'h5555_5555_5555);
        end
      endcase
      no_idle = (ph == 3);
      long_hold = (ph == 2 || ph == 5);
      for (int k = 0; k < 230; k++) begin
        if (k == 115 && ph == 4) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_word(make_packet(), 0, '0);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("[sequenced_event_credit_tracker_core] OK");
    end else begin
      $display("[sequenced_event_credit_tracker_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
